// File: hdl/tas_pkg.sv
// Shared types and constants for the temperature alert and statistics block.
package tas_pkg;

  // Fixed field widths
  localparam int unsigned TempW  = 16;
  localparam int unsigned CountW = 11;
  localparam int unsigned ExcW   = 18;

  // Excursion limits in hundredths of a degree
  localparam logic signed [ExcW-1:0] CritLimit = 18'sd800;
  localparam logic signed [ExcW-1:0] ModLimit  = 18'sd400;

  // Reset values of the threshold registers
  localparam logic signed [TempW-1:0] LowThrReset  = 16'sd1800;
  localparam logic signed [TempW-1:0] HighThrReset = 16'sd2800;

  // Configuration register indexes
  localparam logic CfgLowThr  = 1'b0;
  localparam logic CfgHighThr = 1'b1;

  typedef enum logic [1:0] {
    LVL_NORMAL   = 2'd0,
    LVL_WARNING  = 2'd1,
    LVL_MODERATE = 2'd2,
    LVL_CRITICAL = 2'd3
  } level_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_UPD  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

endpackage

// File: hdl/tas_if.sv
// Sample and result channel interfaces.
interface tas_in_if import tas_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [TempW-1:0] temperature;

  modport source (output valid, output temperature, input ready);
  modport sink   (input valid, input temperature, output ready);
endinterface

interface tas_out_if import tas_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              alert_level;
  logic signed [TempW-1:0] minimum_seen;
  logic signed [TempW-1:0] maximum_seen;
  logic signed [TempW-1:0] mean_value;
  logic [CountW-1:0]       sample_count;
  logic [CountW-1:0]       warning_count;
  logic [CountW-1:0]       moderate_count;
  logic [CountW-1:0]       critical_count;
  logic                    store_full;

  modport source (output valid, output alert_level, output minimum_seen,
                  output maximum_seen, output mean_value, output sample_count,
                  output warning_count, output moderate_count,
                  output critical_count, output store_full, input ready);
  modport sink   (input valid, input alert_level, input minimum_seen,
                  input maximum_seen, input mean_value, input sample_count,
                  input warning_count, input moderate_count,
                  input critical_count, input store_full, output ready);
endinterface

// File: hdl/temperature_alert_statistics.sv
// Top level: sample classification, running statistics and mean sequencer.
// Flow: MAX_SAMPLES sets CntW = clog2(MAX_SAMPLES+1); an accepted sample passes the update,
//   divide and done states before its result is registered in the output register.
// One sample is taken at a time, the next only once the result is loaded, behind the
//   bit-serial mean divider, which produces one quotient bit per cycle.
// Reset: asynchronous, active low; clears statistics, loads thresholds 18.00/28.00.
module temperature_alert_statistics import tas_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic signed [TempW-1:0] cfg_data_i,
  tas_in_if.sink                  sample_i,
  tas_out_if.source               result_o
);

  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SumW = TempW + CntW;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_SAMPLES);

  state_e state_q, state_d;

  logic signed [TempW-1:0] low_thr_q, high_thr_q;
  logic signed [TempW-1:0] sample_q;
  level_e                  level, level_q;
  logic                    full_q;

  logic signed [TempW-1:0] min_q, max_q;
  logic signed [SumW-1:0]  sum_q, sum_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [CntW-1:0]         warn_q, mod_q, crit_q;
  logic                    full;

  logic                    div_start;
  logic                    div_busy;
  logic signed [TempW-1:0] mean;

  logic                    out_valid_q;
  logic                    out_load;

  // Write threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q  <= LowThrReset;
      high_thr_q <= HighThrReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLowThr:  low_thr_q  <= cfg_data_i;
        CfgHighThr: high_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tas_classify u_classify (
    .temperature_i (sample_q),
    .low_thr_i     (low_thr_q),
    .high_thr_i    (high_thr_q),
    .level_o       (level)
  );

  // Sequence one sample: update, divide, hand over to the output register
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (sample_i.valid) state_d = ST_UPD;
      ST_UPD:  state_d = ST_DIV;
      ST_DIV:  if (!div_busy) state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign sample_i.ready = (state_q == ST_IDLE);

  // Hold the accepted sample
  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      sample_q <= sample_i.temperature;
    end
  end

  assign full  = (cnt_q >= MaxCnt);
  assign sum_d = full ? sum_q : sum_q + SumW'(sample_q);
  assign cnt_d = full ? cnt_q : cnt_q + 1'b1;

  // Accumulate statistics while the store has room
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= '0;
      max_q  <= '0;
      sum_q  <= '0;
      cnt_q  <= '0;
      warn_q <= '0;
      mod_q  <= '0;
      crit_q <= '0;
    end else if (state_q == ST_UPD && !full) begin
      if (cnt_q == '0 || sample_q < min_q) begin
        min_q <= sample_q;
      end
      if (cnt_q == '0 || sample_q > max_q) begin
        max_q <= sample_q;
      end
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      case (level)
        LVL_WARNING:  warn_q <= warn_q + 1'b1;
        LVL_MODERATE: mod_q  <= mod_q + 1'b1;
        LVL_CRITICAL: crit_q <= crit_q + 1'b1;
        default: ;
      endcase
    end
  end

  // Hold per-sample classification for the result
  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPD) begin
      level_q <= level;
      full_q  <= full;
    end
  end

  assign div_start = (state_q == ST_UPD);

  tas_div #(
    .DvdW (SumW),
    .DvsW (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .divisor_i  (cnt_d),
    .busy_o     (div_busy),
    .quotient_o (mean)
  );

  // Load the output register once the previous result has been taken
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      result_o.alert_level    <= level_q;
      result_o.minimum_seen   <= (cnt_q == '0) ? '0 : min_q;
      result_o.maximum_seen   <= (cnt_q == '0) ? '0 : max_q;
      result_o.mean_value     <= (cnt_q == '0) ? '0 : mean;
      result_o.sample_count   <= CountW'(cnt_q);
      result_o.warning_count  <= CountW'(warn_q);
      result_o.moderate_count <= CountW'(mod_q);
      result_o.critical_count <= CountW'(crit_q);
      result_o.store_full     <= full_q;
    end
  end

  assign result_o.valid = out_valid_q;

endmodule

// File: hdl/tas_classify.sv
// Excursion computation and alert level classification of one sample.
module tas_classify import tas_pkg::*; (
  input  logic signed [TempW-1:0] temperature_i,
  input  logic signed [TempW-1:0] low_thr_i,
  input  logic signed [TempW-1:0] high_thr_i,
  output level_e                  level_o
);

  logic signed [ExcW-1:0] above;
  logic signed [ExcW-1:0] below;
  logic signed [ExcW-1:0] exc;

  // Take the larger distance outside the comfort band
  assign above = ExcW'(temperature_i) - ExcW'(high_thr_i);
  assign below = ExcW'(low_thr_i) - ExcW'(temperature_i);
  assign exc   = (above > below) ? above : below;

  always_comb begin
    if (exc >= CritLimit) begin
      level_o = LVL_CRITICAL;
    end else if (exc >= ModLimit) begin
      level_o = LVL_MODERATE;
    end else if (exc > 0) begin
      level_o = LVL_WARNING;
    end else begin
      level_o = LVL_NORMAL;
    end
  end

endmodule

// File: hdl/tas_div.sv
// Bit-serial signed divider: one quotient bit per cycle, truncates toward zero.
module tas_div import tas_pkg::*; #(
  parameter int unsigned DvdW = 27,
  parameter int unsigned DvsW = 11
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DvdW-1:0]  dividend_i,
  input  logic [DvsW-1:0]         divisor_i,
  output logic                    busy_o,
  output logic signed [TempW-1:0] quotient_o
);

  localparam int unsigned IterW = $clog2(DvdW + 1);

  logic [DvdW-1:0]  quo_q;
  logic [DvsW-1:0]  rem_q;
  logic [DvsW-1:0]  dvs_q;
  logic             neg_q;
  logic [IterW-1:0] iter_q;

  logic [DvdW-1:0]  mag;
  logic [DvsW:0]    rem_sh;
  logic [DvsW:0]    rem_diff;
  logic             fits;
  logic [DvsW-1:0]  rem_nxt;
  logic [TempW-1:0] quo_lo;

  // Magnitude of the dividend; the sign is applied at the end
  assign mag = dividend_i[DvdW-1] ? DvdW'(-dividend_i) : DvdW'(dividend_i);

  // Shared compare and subtract step
  assign rem_sh   = {rem_q, quo_q[DvdW-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_q};
  assign fits     = (rem_sh >= {1'b0, dvs_q});
  assign rem_nxt  = fits ? rem_diff[DvsW-1:0] : rem_sh[DvsW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
    end else if (start_i) begin
      iter_q <= IterW'(DvdW);
    end else if (busy_o) begin
      iter_q <= iter_q - 1'b1;
    end
  end

  // Load operands, then shift one quotient bit in per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= mag;
      rem_q <= '0;
      dvs_q <= divisor_i;
      neg_q <= dividend_i[DvdW-1];
    end else if (busy_o) begin
      quo_q <= {quo_q[DvdW-2:0], fits};
      rem_q <= rem_nxt;
    end
  end

  assign busy_o     = (iter_q != '0);
  assign quo_lo     = quo_q[TempW-1:0];
  assign quotient_o = neg_q ? -quo_lo : quo_lo;

endmodule

// File: hdl/tas_checker.sv
// Port-level assertions for the temperature alert and statistics block.
module tas_checker import tas_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [TempW-1:0] minimum_seen_i,
  input logic signed [TempW-1:0] maximum_seen_i,
  input logic [CountW-1:0]       sample_count_i,
  input logic                    store_full_i
);

  localparam logic [CountW-1:0] FullCnt = CountW'(MAX_SAMPLES);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(sample_count_i)
      && $stable(minimum_seen_i) && $stable(maximum_seen_i))
    else $error("result changed while stalled");

  // One sample in flight: no transfer right after a transfer
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("sample taken while busy");

  // Minimum never exceeds maximum once a sample has been accumulated
  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> minimum_seen_i <= maximum_seen_i)
    else $error("minimum above maximum");

  // Full store reports the capacity as its count
  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && store_full_i |-> sample_count_i == FullCnt)
    else $error("full flag with wrong sample count");

endmodule

bind temperature_alert_statistics tas_checker #(
  .MAX_SAMPLES (MAX_SAMPLES)
) u_tas_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (sample_i.valid),
  .in_ready_i     (sample_i.ready),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .minimum_seen_i (result_o.minimum_seen),
  .maximum_seen_i (result_o.maximum_seen),
  .sample_count_i (result_o.sample_count),
  .store_full_i   (result_o.store_full)
);

// File: tb/temperature_alert_statistics_checker.sv
// Checker for the temperature alert block: predicts each result and compares it.
`timescale 1ns / 1ps

module temperature_alert_statistics_checker import tas_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic signed [TempW-1:0] cfg_data_i,
  tas_in_if                       sample_mon,
  tas_out_if                      result_mon,
  output int unsigned             fail_count_o,
  output int unsigned             pending_o,
  output int unsigned             checked_o,
  output int unsigned             full_seen_o
);

  typedef struct {
    level_e                  level;
    logic signed [TempW-1:0] lowest;
    logic signed [TempW-1:0] highest;
    logic signed [TempW-1:0] mean;
    logic [CountW-1:0]       samples;
    logic [CountW-1:0]       warnings;
    logic [CountW-1:0]       moderates;
    logic [CountW-1:0]       criticals;
    logic                    full;
  } stats_t;

  // Own copy of the thresholds and the running statistics
  logic signed [TempW-1:0] thr_low;
  logic signed [TempW-1:0] thr_high;
  logic signed [TempW-1:0] acc_min;
  logic signed [TempW-1:0] acc_max;
  longint                  acc_sum;
  int unsigned             acc_count;
  int unsigned             warn_total;
  int unsigned             mod_total;
  int unsigned             crit_total;

  stats_t      stats_q[$];
  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned full_seen;

  assign fail_count_o = mismatches;
  assign pending_o    = pending;
  assign checked_o    = checked;
  assign full_seen_o  = full_seen;

  // Larger of the two excursions against the limits
  function automatic level_e classify_sample(logic signed [TempW-1:0] t);
    int above;
    int below;
    int exc;
    above = int'(t) - int'(thr_high);
    below = int'(thr_low) - int'(t);
    exc   = (above > below) ? above : below;
    if (exc >= int'(CritLimit)) return LVL_CRITICAL;
    if (exc >= int'(ModLimit)) return LVL_MODERATE;
    if (exc > 0) return LVL_WARNING;
    return LVL_NORMAL;
  endfunction

  // Update the statistics with one sample and form the result it yields
  function automatic stats_t predict_stats(logic signed [TempW-1:0] t);
    stats_t r;
    r.level = classify_sample(t);
    r.full  = (acc_count >= MAX_SAMPLES);
    if (!r.full) begin
      if (acc_count == 0) begin
        acc_min = t;
        acc_max = t;
      end else begin
        if (t < acc_min) acc_min = t;
        if (t > acc_max) acc_max = t;
      end
      acc_sum += longint'(t);
      acc_count++;
      case (r.level)
        LVL_WARNING:  warn_total++;
        LVL_MODERATE: mod_total++;
        LVL_CRITICAL: crit_total++;
        default: ;
      endcase
    end
    r.lowest    = acc_min;
    r.highest   = acc_max;
    r.mean      = (acc_count != 0) ? TempW'(acc_sum / longint'(acc_count)) : '0;
    r.samples   = CountW'(acc_count);
    r.warnings  = CountW'(warn_total);
    r.moderates = CountW'(mod_total);
    r.criticals = CountW'(crit_total);
    return r;
  endfunction

  function automatic void check_field(string field, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s of result %0d wrong: expected %0d, got %0d",
                 $realtime, field, checked, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : track
    stats_t want;
    if (!rst_ni) begin
      thr_low    = LowThrReset;
      thr_high   = HighThrReset;
      acc_min    = '0;
      acc_max    = '0;
      acc_sum    = 0;
      acc_count  = 0;
      warn_total = 0;
      mod_total  = 0;
      crit_total = 0;
      stats_q.delete();
    end else begin
      // Compare each result transfer with the oldest prediction
      if (result_mon.valid === 1'b1 && result_mon.ready === 1'b1) begin
        if (stats_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result transfer with no sample waiting for it", $realtime);
        end else begin
          want = stats_q.pop_front();
          check_field("alert_level", want.level, result_mon.alert_level);
          check_field("minimum_seen", want.lowest, result_mon.minimum_seen);
          check_field("maximum_seen", want.highest, result_mon.maximum_seen);
          check_field("mean_value", want.mean, result_mon.mean_value);
          check_field("sample_count", want.samples, result_mon.sample_count);
          check_field("warning_count", want.warnings, result_mon.warning_count);
          check_field("moderate_count", want.moderates, result_mon.moderate_count);
          check_field("critical_count", want.criticals, result_mon.critical_count);
          check_field("store_full", want.full, result_mon.store_full);
          if (want.full) full_seen++;
          checked++;
        end
      end
      // Predict on each sample transfer
      if (sample_mon.valid === 1'b1 && sample_mon.ready === 1'b1)
        stats_q.push_back(predict_stats(sample_mon.temperature));
      // Track threshold writes
      if (cfg_we_i === 1'b1) begin
        if (cfg_idx_i == CfgLowThr) thr_low = cfg_data_i;
        else thr_high = cfg_data_i;
      end
    end
    pending = stats_q.size();
  end

endmodule

// File: tb/temperature_alert_statistics_tb.sv
// Top of the temperature alert testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module temperature_alert_statistics_tb import tas_pkg::*; ();

  localparam int unsigned MaxSamples     = 1024;
  localparam int unsigned CycleLimit     = 1_000_000;
  localparam int unsigned DrainCycles    = 40;
  localparam int unsigned RandomPerPhase = 250;
  localparam int          Phases         = 8;

  typedef enum logic [1:0] {
    PACE_NONE,
    PACE_SRC,
    PACE_SINK,
    PACE_BOTH
  } pace_e;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_we;
  logic                    cfg_idx;
  logic signed [TempW-1:0] cfg_data;
  logic signed [TempW-1:0] cur_low;
  logic signed [TempW-1:0] cur_high;
  pace_e                   pace;
  int unsigned             cycles;
  int unsigned             samples_sent;
  int unsigned             fail_count;
  int unsigned             pending;
  int unsigned             checked;
  int unsigned             full_seen;

  tas_in_if  sample_if ();
  tas_out_if result_if ();

  temperature_alert_statistics #(
    .MAX_SAMPLES(MaxSamples)
  ) dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .sample_i  (sample_if),
    .result_o  (result_if)
  );

  temperature_alert_statistics_checker #(
    .MAX_SAMPLES(MaxSamples)
  ) checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .sample_mon  (sample_if),
    .result_mon  (result_if),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .full_seen_o (full_seen)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bound the run length
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still expected", cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // True, at random, when this side should hold off
  function automatic bit hold_off(bit active);
    int unsigned pct;
    pct = (pace == PACE_BOTH) ? 25 : 76;
    return active && ($urandom_range(0, 99) < pct);
  endfunction

  // Stall the result side at random
  always @(negedge clk) begin
    result_if.ready <= !hold_off(pace == PACE_SINK || pace == PACE_BOTH);
  end

  // Pick a sample, partly around the thresholds and the level boundaries, partly across the range
  function automatic logic signed [TempW-1:0] pick_temperature();
    int          v;
    int          base;
    int unsigned r;
    int          offsets[7] = '{0, 1, 399, 400, 799, 800, 801};
    r    = $urandom_range(0, 99);
    base = $urandom_range(0, 1) ? int'(cur_low) : int'(cur_high);
    if (r < 20) begin
      v = base + ($urandom_range(0, 1) ? offsets[$urandom_range(0, 6)]
                                       : -offsets[$urandom_range(0, 6)]);
    end else if (r < 45) begin
      v = base + int'($urandom_range(0, 2000)) - 1000;
    end else if (r < 65) begin
      v = $signed(16'($urandom));
    end else if (r < 75) begin
      case ($urandom_range(0, 3))
        0:       v = 32767;
        1:       v = -32768;
        2:       v = 0;
        default: v = -1;
      endcase
    end else begin
      v = int'($urandom_range(0, 15000)) - 5000;
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return TempW'(v);
  endfunction

  // Offer one sample and hold it until the transfer
  task automatic send_sample(input logic signed [TempW-1:0] t);
    while (hold_off(pace == PACE_SRC || pace == PACE_BOTH)) begin
      sample_if.valid <= 1'b0;
      @(negedge clk);
    end
    sample_if.valid       <= 1'b1;
    sample_if.temperature <= t;
    do @(posedge clk); while (sample_if.ready !== 1'b1);
    @(negedge clk);
    samples_sent++;
  endtask

  // Drop valid and let every outstanding result drain
  task automatic wait_idle();
    sample_if.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // Write both thresholds on consecutive edges
  task automatic set_thresholds(input logic signed [TempW-1:0] lo,
                                input logic signed [TempW-1:0] hi);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgLowThr;
    cfg_data <= lo;
    @(negedge clk);
    cfg_idx  <= CfgHighThr;
    cfg_data <= hi;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_low  = lo;
    cur_high = hi;
    @(negedge clk);
  endtask

  initial begin
    // Level boundaries at the reset thresholds, field extremes, signs
    logic signed [TempW-1:0] directed[18] = '{
      16'sd2800, 16'sd2801, 16'sd3199, 16'sd3200, 16'sd3599, 16'sd3600,
      16'sd1800, 16'sd1799, 16'sd1401, 16'sd1400, 16'sd1001, 16'sd1000,
      16'sd2300, 16'sd32767, -16'sd32768, 16'sd0, -16'sd1, -16'sd32767
    };
    logic signed [TempW-1:0] phase_low[Phases] = '{
      16'sd1800, 16'sd3000, -16'sd32768, 16'sd32767,
      16'sd2000, 16'sd0, -16'sd1000, 16'sd1800
    };
    logic signed [TempW-1:0] phase_high[Phases] = '{
      16'sd2800, 16'sd1000, 16'sd32767, -16'sd32768,
      16'sd2000, 16'sd0, 16'sd500, 16'sd2800
    };
    pace_e phase_pace[Phases] = '{
      PACE_NONE, PACE_SRC, PACE_SINK, PACE_BOTH,
      PACE_NONE, PACE_SRC, PACE_SINK, PACE_BOTH
    };

    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = CfgLowThr;
    cfg_data              = '0;
    sample_if.valid       = 1'b0;
    sample_if.temperature = '0;
    cur_low               = LowThrReset;
    cur_high              = HighThrReset;
    pace                  = PACE_NONE;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed samples against the reset thresholds
    foreach (directed[i]) send_sample(directed[i]);
    wait_idle();

    // Random phases, each with its own thresholds and pacing
    for (int p = 0; p < Phases; p++) begin
      if (p == 5) set_thresholds($signed(16'($urandom)), $signed(16'($urandom)));
      else set_thresholds(phase_low[p], phase_high[p]);
      pace = phase_pace[p];
      repeat (RandomPerPhase) send_sample(pick_temperature());
      wait_idle();
      pace = PACE_NONE;
    end

    $display("Summary: %0d samples sent across %0d threshold settings and four pacing modes",
             samples_sent, Phases + 1);
    $display("Summary: %0d results checked, %0d with the store full, %0d mismatches",
             checked, full_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/tas_pkg.sv
hdl/tas_if.sv
hdl/tas_classify.sv
hdl/tas_div.sv
hdl/temperature_alert_statistics.sv
hdl/tas_checker.sv
tb/temperature_alert_statistics_checker.sv
tb/temperature_alert_statistics_tb.sv
